// ----- design/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Packet flow classifier package
// Shared widths, codes and control types for the flow classifier block.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  // Default number of flow table entries.
  localparam int FLOW_ENTRIES_DEF = 256;

  // Ethertype and protocol codes.
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // Packet class codes.
  localparam logic [1:0] CLS_TCP   = 2'd0;
  localparam logic [1:0] CLS_UDP   = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  // Stored key: tag, four address halves and the port pair.
  localparam int KEY_W = 3 + 4 * 64 + 32;

  // Saturation limit of the flow totals.
  localparam logic [8:0] FLOW_MAX = 9'd511;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // Capture the input word and update packet counters.
    logic search;  // Step the table search.
    logic commit;  // Apply the search result to the table and flow totals.
  } pfc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;    // The search has finished this cycle.
  } pfc_sts_t;

endpackage

`default_nettype wire

// ----- design/pfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Packet flow classifier controller
// Sequences accept, table search, commit and result handoff for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output pfc_pkg::pfc_cmd_t     cmd,
  input  wire pfc_pkg::pfc_sts_t sts
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_OUT    = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.search = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.done) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

endmodule

`default_nettype wire

// ----- design/pfc_dp.sv -----
// ----------------------------------------------------------------------------
// Packet flow classifier datapath
// Key capture, flow table memory with linear search, and saturating counters.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_dp #(
  parameter int FLOW_ENTRIES = pfc_pkg::FLOW_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfc_pkg::pfc_cmd_t cmd,
  output pfc_pkg::pfc_sts_t      sts,
  input  wire logic [15:0]       in_ether_type,
  input  wire logic [7:0]        in_next_protocol,
  input  wire logic [63:0]       in_src_addr_hi,
  input  wire logic [63:0]       in_src_addr_lo,
  input  wire logic [63:0]       in_dst_addr_hi,
  input  wire logic [63:0]       in_dst_addr_lo,
  input  wire logic [15:0]       in_src_port,
  input  wire logic [15:0]       in_dst_port,
  input  wire logic [15:0]       in_frame_length,
  output logic [1:0]             out_packet_class,
  output logic                   out_new_flow,
  output logic                   out_table_full,
  output logic [8:0]             out_tcp_flows,
  output logic [8:0]             out_udp_flows,
  output logic [31:0]            out_tcp_packets,
  output logic [31:0]            out_udp_packets,
  output logic [31:0]            out_other_packets,
  output logic [47:0]            out_tcp_bytes,
  output logic [47:0]            out_udp_bytes
);

  localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FLOW_ENTRIES);
  localparam int KW = pfc_pkg::KEY_W;

  // Flow table and search state.
  logic [KW-1:0]    mem [FLOW_ENTRIES];
  logic [KW-1:0]    rd_data_r;
  logic [KW-1:0]    key_r;
  logic [1:0]       cls_r;
  logic             new_r;
  logic             full_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic             cmp_vld_r;
  logic [8:0]       tcp_flows_r;
  logic [8:0]       udp_flows_r;
  logic [31:0]      tcp_pkts_r;
  logic [31:0]      udp_pkts_r;
  logic [31:0]      oth_pkts_r;
  logic [47:0]      tcp_bytes_r;
  logic [47:0]      udp_bytes_r;

  logic             is_v4;
  logic             is_v6;
  logic [1:0]       cls_in;
  logic [KW-1:0]    key_in;
  logic [48:0]      tcp_sum;
  logic [48:0]      udp_sum;
  logic             match;
  logic             issue;
  logic             is_other;

  // Classification and key formation for the incoming word.
  always_comb begin
    is_v4  = (in_ether_type == pfc_pkg::ETH_IPV4);
    is_v6  = (in_ether_type == pfc_pkg::ETH_IPV6);
    cls_in = pfc_pkg::CLS_OTHER;
    if ((is_v4 || is_v6) && (in_next_protocol == pfc_pkg::PROTO_TCP)) begin
      cls_in = pfc_pkg::CLS_TCP;
    end else if ((is_v4 || is_v6) && (in_next_protocol == pfc_pkg::PROTO_UDP)) begin
      cls_in = pfc_pkg::CLS_UDP;
    end
    key_in = {is_v6, cls_in[0], 1'b1,
              is_v6 ? in_src_addr_hi : 64'd0,
              is_v6 ? in_src_addr_lo : {32'd0, in_src_addr_lo[31:0]},
              is_v6 ? in_dst_addr_hi : 64'd0,
              is_v6 ? in_dst_addr_lo : {32'd0, in_dst_addr_lo[31:0]},
              in_src_port, in_dst_port};
  end

  // Byte sums with a carry bit for saturation.
  assign tcp_sum = {1'b0, tcp_bytes_r} + {33'd0, in_frame_length};
  assign udp_sum = {1'b0, udp_bytes_r} + {33'd0, in_frame_length};

  // Search step: compare last read entry, issue the next read.
  assign is_other = (cls_r == pfc_pkg::CLS_OTHER);
  assign match    = cmp_vld_r && (rd_data_r == key_r);
  assign issue    = cmd.search && !match && !is_other && (rd_idx_r < count_r);
  assign sts.done = is_other || match || (!cmp_vld_r && (rd_idx_r >= count_r));

  // Flow table memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
    if (cmd.commit && !is_other && !match && (count_r != CNT_FULL)) begin
      mem[count_r[IDX_W-1:0]] <= key_r;
    end
  end

  // Captured key; the class is captured with the control registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= key_in;
    end
  end

  // Control and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r       <= pfc_pkg::CLS_OTHER;
      new_r       <= 1'b0;
      full_r      <= 1'b0;
      count_r     <= '0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      tcp_flows_r <= '0;
      udp_flows_r <= '0;
      tcp_pkts_r  <= '0;
      udp_pkts_r  <= '0;
      oth_pkts_r  <= '0;
      tcp_bytes_r <= '0;
      udp_bytes_r <= '0;
    end else begin
      if (cmd.load) begin
        cls_r     <= cls_in;
        new_r     <= 1'b0;
        full_r    <= 1'b0;
        rd_idx_r  <= '0;
        cmp_vld_r <= 1'b0;
        unique case (cls_in)
          pfc_pkg::CLS_TCP: begin
            if (tcp_pkts_r != '1) tcp_pkts_r <= tcp_pkts_r + 32'd1;
            tcp_bytes_r <= tcp_sum[48] ? '1 : tcp_sum[47:0];
          end
          pfc_pkg::CLS_UDP: begin
            if (udp_pkts_r != '1) udp_pkts_r <= udp_pkts_r + 32'd1;
            udp_bytes_r <= udp_sum[48] ? '1 : udp_sum[47:0];
          end
          default: begin
            if (oth_pkts_r != '1) oth_pkts_r <= oth_pkts_r + 32'd1;
          end
        endcase
      end
      if (cmd.search) begin
        cmp_vld_r <= issue;
        if (issue) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
      end
      // A flow not found is appended, or flagged when the table is full.
      if (cmd.commit && !is_other && !match) begin
        if (count_r == CNT_FULL) begin
          full_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
          new_r   <= 1'b1;
          if (cls_r == pfc_pkg::CLS_TCP) begin
            if (tcp_flows_r != pfc_pkg::FLOW_MAX) tcp_flows_r <= tcp_flows_r + 9'd1;
          end else begin
            if (udp_flows_r != pfc_pkg::FLOW_MAX) udp_flows_r <= udp_flows_r + 9'd1;
          end
        end
      end
    end
  end

  assign out_packet_class  = cls_r;
  assign out_new_flow      = new_r;
  assign out_table_full    = full_r;
  assign out_tcp_flows     = tcp_flows_r;
  assign out_udp_flows     = udp_flows_r;
  assign out_tcp_packets   = tcp_pkts_r;
  assign out_udp_packets   = udp_pkts_r;
  assign out_other_packets = oth_pkts_r;
  assign out_tcp_bytes     = tcp_bytes_r;
  assign out_udp_bytes     = udp_bytes_r;

endmodule

`default_nettype wire

// ----- design/packet_flow_classifier_core.sv -----
// ----------------------------------------------------------------------------
// Packet flow classifier core
// Classifies packets as TCP, UDP or other, keeps saturating counters and
// learns distinct flows in a linearly searched table.
// ----------------------------------------------------------------------------
// One word is handled at a time. For a TCP or UDP word the search time grows
// with N, the number of flows stored so far (at most FLOW_ENTRIES): the
// flow table memory is read one entry per cycle and each entry is compared
// in the next. Other words skip the table search. The result is held until
// taken, and the next word is accepted the cycle after.
`default_nettype none

module packet_flow_classifier_core #(
  parameter int FLOW_ENTRIES = pfc_pkg::FLOW_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_ether_type,
  input  wire logic [7:0]  in_next_protocol,
  input  wire logic [63:0] in_src_addr_hi,
  input  wire logic [63:0] in_src_addr_lo,
  input  wire logic [63:0] in_dst_addr_hi,
  input  wire logic [63:0] in_dst_addr_lo,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic [15:0] in_frame_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_packet_class,
  output logic             out_new_flow,
  output logic             out_table_full,
  output logic [8:0]       out_tcp_flows,
  output logic [8:0]       out_udp_flows,
  output logic [31:0]      out_tcp_packets,
  output logic [31:0]      out_udp_packets,
  output logic [31:0]      out_other_packets,
  output logic [47:0]      out_tcp_bytes,
  output logic [47:0]      out_udp_bytes
);

  pfc_pkg::pfc_cmd_t cmd;
  pfc_pkg::pfc_sts_t sts;

  // Controller.
  pfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath.
  pfc_dp #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_ether_type     (in_ether_type),
    .in_next_protocol  (in_next_protocol),
    .in_src_addr_hi    (in_src_addr_hi),
    .in_src_addr_lo    (in_src_addr_lo),
    .in_dst_addr_hi    (in_dst_addr_hi),
    .in_dst_addr_lo    (in_dst_addr_lo),
    .in_src_port       (in_src_port),
    .in_dst_port       (in_dst_port),
    .in_frame_length   (in_frame_length),
    .out_packet_class  (out_packet_class),
    .out_new_flow      (out_new_flow),
    .out_table_full    (out_table_full),
    .out_tcp_flows     (out_tcp_flows),
    .out_udp_flows     (out_udp_flows),
    .out_tcp_packets   (out_tcp_packets),
    .out_udp_packets   (out_udp_packets),
    .out_other_packets (out_other_packets),
    .out_tcp_bytes     (out_tcp_bytes),
    .out_udp_bytes     (out_udp_bytes)
  );

endmodule

`default_nettype wire

// ----- design/pfc_checker.sv -----
// ----------------------------------------------------------------------------
// Packet flow classifier checker
// Port-level assertions on result consistency and word sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_packet_class,
  input wire logic       out_new_flow,
  input wire logic       out_table_full
);

  // No new word is taken while a result is pending.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("word accepted with result pending");

  // A flow is either added or rejected, never both.
  a_new_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_new_flow && out_table_full)) else $error("new and full");

  // Other packets never touch the flow table.
  a_other_no_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_packet_class == pfc_pkg::CLS_OTHER) |->
      (!out_new_flow && !out_table_full)) else $error("other packet flagged flow");

  // A taken result is not shown again.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");

endmodule

bind packet_flow_classifier_core pfc_checker u_pfc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_packet_class (out_packet_class),
  .out_new_flow     (out_new_flow),
  .out_table_full   (out_table_full)
);

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Flow classifier core testbench
// Drives packet header words through the classifier with random gaps and
// stalls on both sides and checks every result word against a behavioral
// model of the class counters and the learned flow table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

  localparam int FLOWS = pfc_pkg::FLOW_ENTRIES_DEF;

  // One packet header word.
  typedef struct {
    logic [15:0] eth;
    logic [7:0]  proto;
    logic [63:0] sh, sl, dh, dl;
    logic [15:0] sp, dp, flen;
  } hdr_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  cls;
    logic        added, full;
    logic [8:0]  tflows, uflows;
    logic [31:0] tpk, upk, opk;
    logic [47:0] tby, uby;
  } res_t;

  // One directed row; has_exp marks rows with typed-in values.
  typedef struct {
    hdr_t hdr;
    bit   has_exp;
    res_t exp;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  hdr_t drv;
  res_t got;

  packet_flow_classifier_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ether_type(drv.eth), .in_next_protocol(drv.proto),
    .in_src_addr_hi(drv.sh), .in_src_addr_lo(drv.sl),
    .in_dst_addr_hi(drv.dh), .in_dst_addr_lo(drv.dl),
    .in_src_port(drv.sp), .in_dst_port(drv.dp), .in_frame_length(drv.flen),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_packet_class(got.cls), .out_new_flow(got.added),
    .out_table_full(got.full), .out_tcp_flows(got.tflows),
    .out_udp_flows(got.uflows), .out_tcp_packets(got.tpk),
    .out_udp_packets(got.upk), .out_other_packets(got.opk),
    .out_tcp_bytes(got.tby), .out_udp_bytes(got.uby)
  );

  // Model state: flow table keys and running totals.
  logic [2:0]   tag_q [FLOWS];
  logic [287:0] key_q [FLOWS];
  int unsigned  stored;
  res_t         totals;
  res_t         pending [$];
  bit           pending_directed [$];
  res_t         directed_exp [$];
  int           errors;
  int           hold_off;

  // Compute the expected result of one header word and update the model.
  function automatic res_t classify_packet(hdr_t h);
    res_t r;
    logic [2:0] tg;
    logic [287:0] k;
    bit v6, hit;
    r = totals;
    r.added = 1'b0;
    r.full = 1'b0;
    v6 = (h.eth == pfc_pkg::ETH_IPV6);
    if ((h.eth == pfc_pkg::ETH_IPV4 || v6) &&
        (h.proto == pfc_pkg::PROTO_TCP || h.proto == pfc_pkg::PROTO_UDP))
      r.cls = (h.proto == pfc_pkg::PROTO_TCP) ? pfc_pkg::CLS_TCP : pfc_pkg::CLS_UDP;
    else
      r.cls = pfc_pkg::CLS_OTHER;
    if (r.cls == pfc_pkg::CLS_OTHER) begin
      if (r.opk != '1) r.opk++;
    end else begin
      if (r.cls == pfc_pkg::CLS_TCP) begin
        if (r.tpk != '1) r.tpk++;
        r.tby = ({1'b0, r.tby} + h.flen > 49'hFFFF_FFFF_FFFF) ? '1 : r.tby + h.flen;
      end else begin
        if (r.upk != '1) r.upk++;
        r.uby = ({1'b0, r.uby} + h.flen > 49'hFFFF_FFFF_FFFF) ? '1 : r.uby + h.flen;
      end
      tg = {v6, r.cls[0], 1'b1};
      if (v6) k = {h.sh, h.sl, h.dh, h.dl, h.sp, h.dp};
      else k = {64'd0, 32'd0, h.sl[31:0], 64'd0, 32'd0, h.dl[31:0], h.sp, h.dp};
      hit = 1'b0;
      for (int i = 0; i < stored; i++)
        if (tag_q[i] == tg && key_q[i] == k) hit = 1'b1;
      if (!hit) begin
        if (stored >= FLOWS) r.full = 1'b1;
        else begin
          tag_q[stored] = tg;
          key_q[stored] = k;
          stored++;
          r.added = 1'b1;
          if (r.cls == pfc_pkg::CLS_TCP) begin
            if (r.tflows != pfc_pkg::FLOW_MAX) r.tflows++;
          end else if (r.uflows != pfc_pkg::FLOW_MAX) r.uflows++;
        end
      end
    end
    totals = r;
    return r;
  endfunction

  // Clock.
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Random gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls plus the long hold-off when requested.
  initial begin
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall <= 1;
        hold_off--;
      end else if ($urandom_range(0, 99) < 25) out_stall <= 1;
      else out_stall <= 0;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("result word with no expectation");
        errors++;
      end else begin
        e = pending.pop_front();
        if (pending_directed.pop_front()) begin
          res_t d;
          d = directed_exp.pop_front();
          if (d != e) begin
            $error("directed expectation disagrees with predictor");
            errors++;
          end
        end
        if (got.cls !== e.cls) begin
          $error("packet_class exp %0d got %0d", e.cls, got.cls); errors++; end
        if (got.added !== e.added) begin
          $error("new_flow exp %0d got %0d", e.added, got.added); errors++; end
        if (got.full !== e.full) begin
          $error("table_full exp %0d got %0d", e.full, got.full); errors++; end
        if (got.tflows !== e.tflows) begin
          $error("tcp_flows exp %0d got %0d", e.tflows, got.tflows); errors++; end
        if (got.uflows !== e.uflows) begin
          $error("udp_flows exp %0d got %0d", e.uflows, got.uflows); errors++; end
        if (got.tpk !== e.tpk) begin
          $error("tcp_packets exp %0d got %0d", e.tpk, got.tpk); errors++; end
        if (got.upk !== e.upk) begin
          $error("udp_packets exp %0d got %0d", e.upk, got.upk); errors++; end
        if (got.opk !== e.opk) begin
          $error("other_packets exp %0d got %0d", e.opk, got.opk); errors++; end
        if (got.tby !== e.tby) begin
          $error("tcp_bytes exp %0d got %0d", e.tby, got.tby); errors++; end
        if (got.uby !== e.uby) begin
          $error("udp_bytes exp %0d got %0d", e.uby, got.uby); errors++; end
      end
    end
  end

  // Send one word: set it up at the falling edge and hold until accepted.
  task automatic send_word(hdr_t h, bit has_exp, res_t ex);
    int g;
    g = gap_len();
    repeat (g) begin
      in_valid <= 0;
      @(negedge clk);
    end
    drv <= h;
    in_valid <= 1;
    pending.push_back(classify_packet(h));
    pending_directed.push_back(has_exp);
    if (has_exp) directed_exp.push_back(ex);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic hdr_t mk(logic [15:0] e, logic [7:0] p, logic [63:0] s,
                              logic [63:0] d, logic [15:0] sp, logic [15:0] dp,
                              logic [15:0] fl);
    hdr_t h;
    h.eth = e; h.proto = p;
    h.sh = s ^ 64'hA5A5_0000_FFFF_1234; h.sl = s;
    h.dh = ~d; h.dl = d;
    h.sp = sp; h.dp = dp; h.flen = fl;
    return h;
  endfunction

  // Random header, biased toward TCP/UDP and a small pool of repeated flows.
  function automatic hdr_t rand_hdr();
    hdr_t h;
    int p;
    p = $urandom_range(0, 99);
    h.sh = {$urandom, $urandom}; h.sl = {$urandom, $urandom};
    h.dh = {$urandom, $urandom}; h.dl = {$urandom, $urandom};
    h.sp = 16'($urandom); h.dp = 16'($urandom); h.flen = 16'($urandom);
    h.eth = $urandom_range(0, 1) ? pfc_pkg::ETH_IPV4 : pfc_pkg::ETH_IPV6;
    h.proto = $urandom_range(0, 1) ? pfc_pkg::PROTO_TCP : pfc_pkg::PROTO_UDP;
    if (p < 45) begin
      // Reuse a small flow pool so hits are common.
      h.sh = 64'($urandom_range(0, 1)); h.sl = 64'($urandom_range(0, 3));
      h.dh = '0; h.dl = 64'($urandom_range(0, 3));
      h.sp = 16'($urandom_range(0, 1)); h.dp = 16'd80;
    end else if (p < 85) begin
      // new flow with random content
    end else if (p < 93) begin
      h.proto = 8'($urandom);
    end else begin
      h.eth = 16'($urandom);
    end
    return h;
  endfunction

  // Wait until every expected word has come back.
  task automatic drain();
    in_valid <= 0;
    while (pending.size() != 0) @(negedge clk);
  endtask

  row_t rows [$];

  initial begin
    row_t r;
    res_t z;
    hdr_t h;
    errors = 0; hold_off = 0; stored = 0;
    totals = '{cls: pfc_pkg::CLS_OTHER, default: '0};
    rst_n = 0; in_valid = 0;
    drv = '{default: '0};
    z = '{cls: pfc_pkg::CLS_OTHER, default: '0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed table: first rows have typed-in expectations.
    r.has_exp = 1;
    r.hdr = mk(16'hFFFF, 8'hFF, '1, '1, '1, '1, '1);
    r.exp = z; r.exp.opk = 32'd1; rows.push_back(r);
    r.hdr = mk(pfc_pkg::ETH_IPV4, pfc_pkg::PROTO_TCP, '0, '0, 16'd0, 16'd0, 16'hFFFF);
    r.exp = z; r.exp.cls = pfc_pkg::CLS_TCP; r.exp.added = 1'b1; r.exp.tflows = 9'd1;
    r.exp.tpk = 32'd1; r.exp.tby = 48'hFFFF; r.exp.opk = 32'd1; rows.push_back(r);
    r.hdr = mk(pfc_pkg::ETH_IPV6, pfc_pkg::PROTO_UDP, '1, '1, 16'hFFFF, 16'hFFFF,
               16'd0);
    r.exp = z; r.exp.cls = pfc_pkg::CLS_UDP; r.exp.added = 1'b1; r.exp.tflows = 9'd1;
    r.exp.uflows = 9'd1; r.exp.tpk = 32'd1; r.exp.upk = 32'd1; r.exp.opk = 32'd1;
    r.exp.tby = 48'hFFFF; rows.push_back(r);
    r.has_exp = 0;
    // IPv4 key ignores the high halves and upper low bits: a hit.
    r.hdr = mk(pfc_pkg::ETH_IPV4, pfc_pkg::PROTO_TCP, 64'hFFFF_FFFF_0000_0000,
               64'hDEAD_0000_0000_0000, 16'd0, 16'd0, 16'd1);
    rows.push_back(r);
    // Same addresses, other class and version: distinct flows; then a repeat of the IPv6 UDP flow.
    r.hdr = mk(pfc_pkg::ETH_IPV4, pfc_pkg::PROTO_UDP, '0, '0, 16'd0, 16'd0, 16'd1);
    rows.push_back(r);
    r.hdr = mk(pfc_pkg::ETH_IPV6, pfc_pkg::PROTO_TCP, '0, '0, 16'd0, 16'd0, 16'd1);
    rows.push_back(r);
    r.hdr = mk(pfc_pkg::ETH_IPV6, pfc_pkg::PROTO_UDP, '1, '1, 16'hFFFF, 16'hFFFF,
               16'd5);
    rows.push_back(r);
    r.hdr = mk(pfc_pkg::ETH_IPV6, 8'd7, '1, '1, 16'd1, 16'd1, 16'd5); rows.push_back(r);
    r.hdr = mk(16'h0806, pfc_pkg::PROTO_TCP, '1, '1, 16'd1, 16'd1, 16'd5);
    rows.push_back(r);
    r.hdr = mk(16'h86DC, pfc_pkg::PROTO_UDP, '0, '0, 16'd1, 16'd1, 16'd5);
    rows.push_back(r);
    r.hdr = mk(pfc_pkg::ETH_IPV4, 8'd0, '0, '0, 16'd1, 16'd1, 16'd0); rows.push_back(r);
    r.hdr = mk(pfc_pkg::ETH_IPV4, pfc_pkg::PROTO_TCP, 64'd1, 64'd2, 16'h8000, 16'h0001,
               16'h8000);
    rows.push_back(r);
    r.hdr = mk(pfc_pkg::ETH_IPV4, pfc_pkg::PROTO_TCP, 64'd1, 64'd2, 16'h0001, 16'h8000,
               16'h8000);
    rows.push_back(r);
    foreach (rows[i]) send_word(rows[i].hdr, rows[i].has_exp, rows[i].exp);
    drain();

    // Receiver holds off while the sender keeps offering words.
    hold_off = 60;
    for (int i = 0; i < 6; i++) send_word(rand_hdr(), 0, z);
    drain();

    // Random part; halfway, fill the table to exercise the full case.
    for (int n = 0; n < 650; n++) begin
      if (n == 325) begin
        drain();
        while (stored < FLOWS) begin
          h = rand_hdr();
          h.eth = pfc_pkg::ETH_IPV4; h.proto = pfc_pkg::PROTO_UDP;
          h.sl = 64'(n * 1000 + stored);
          send_word(h, 0, z);
        end
      end
      send_word(rand_hdr(), 0, z);
    end
    drain();
    repeat (FLOWS + 20) @(negedge clk);
    if (errors == 0 && pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/pfc_pkg.sv
design/pfc_ctrl.sv
design/pfc_dp.sv
design/packet_flow_classifier_core.sv
design/pfc_checker.sv
test/tb.sv
